// ----- src/sbc_pkg.sv -----
// shared types, constants and control structs for the spectrum background colorizer
`default_nettype none

package sbc_pkg;

  localparam int CHANNELS = 512;
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int ACC_W = 20;
  localparam int PROD_W = 41;
  localparam int RECIP_SHIFT = 24;
  localparam logic [20:0] RECIP11 = 21'((2 ** RECIP_SHIFT) / 11);

  localparam int DVD_W = 17;
  localparam logic [4:0] DIV_LAST = 5'(DVD_W - 1);

  localparam logic signed [18:0] VBIAS = 19'sd32512;

  localparam logic [1:0] MODE_RAW = 2'd0;
  localparam logic [1:0] MODE_SMOOTH = 2'd1;
  localparam logic [1:0] MODE_FIXED = 2'd2;

  typedef enum logic [1:0] {
    CFG_MODE,
    CFG_LOW,
    CFG_HIGH,
    CFG_CHANNELS
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] sample;
    logic [8:0] channel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_MUL,
    ST_UPDATE,
    ST_WIDEN,
    ST_DIVIDE,
    ST_FINISH
  } sbc_state_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic rd;
    logic acc;
    logic mul;
    logic update;
    logic widen;
    logic div_init;
    logic div_step;
    logic out_load;
  } sbc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic narrow;
    logic div_last;
    logic out_free;
  } sbc_status_t;

endpackage

`default_nettype wire

// ----- src/sbc_ctrl.sv -----
// sequencing state machine for the colorizer
`default_nettype none

module sbc_ctrl
  import sbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire sbc_status_t status,
  output sbc_cmd_t         cmd
);

  sbc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt = ST_WIDEN;
      end
      ST_WIDEN: begin
        if (status.narrow) begin
          cmd.widen = 1'b1;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/sbc_datapath.sv -----
// background store, smoothing arithmetic, window divider and rainbow colour map
`default_nettype none

module sbc_datapath
  import sbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire sbc_cmd_t    cmd,
  output sbc_status_t      status,
  input  wire in_item_t    in_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data,
  input  wire logic        out_stall,
  output logic             out_valid,
  output out_item_t        out_data
);

  // configuration
  logic [1:0] mode_r;
  logic [7:0] low_r;
  logic [7:0] high_r;
  logic [9:0] chans_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RAW;
      low_r <= 8'd0;
      high_r <= 8'd255;
      chans_r <= 10'd512;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:     mode_r <= cfg_data[1:0];
        CFG_LOW:      low_r <= cfg_data[7:0];
        CFG_HIGH:     high_r <= cfg_data[7:0];
        CFG_CHANNELS: chans_r <= cfg_data;
      endcase
    end
  end

  logic raw;
  assign raw = (mode_r != MODE_SMOOTH) && (mode_r != MODE_FIXED);

  // background store and clearing pass
  logic [15:0] mem [CHANNELS];
  logic [IDX_W-1:0] clr_cnt_r;
  logic [IDX_W-1:0] p_r;
  logic [7:0] z_r;
  logic [15:0] rd_data_r;
  logic [15:0] bg_new;
  logic [15:0] bg_r;
  logic captured_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_cnt_r] <= 16'd0;
    end else if (cmd.update) begin
      mem[p_r] <= bg_new;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[p_r];
    end
  end

  // smoothing: divide by eleven through a reciprocal with one correction
  logic [ACC_W-1:0] acc_r;
  logic [PROD_W-1:0] prod_r;
  logic [16:0] q_est;
  logic [20:0] q_times11;
  logic [20:0] q_rem;
  logic [15:0] q_smooth;

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      acc_r <= ACC_W'(rd_data_r) * 20'd10 + {4'b0, z_r, 8'b0} + 20'd5;
    end
    if (cmd.mul) begin
      prod_r <= {21'b0, acc_r} * {20'b0, RECIP11};
    end
  end

  always_comb begin
    q_est = prod_r[PROD_W-1:RECIP_SHIFT];
    q_times11 = 21'(q_est) * 21'd11;
    q_rem = {1'b0, acc_r} - q_times11;
    if (q_rem >= 21'd11) begin
      q_smooth = 16'(q_est + 17'd1);
    end else begin
      q_smooth = q_est[15:0];
    end
  end

  logic cap_now;
  assign cap_now = ({1'b0, p_r} + 10'd1) >= chans_r;

  always_comb begin
    if (raw) begin
      bg_new = 16'd0;
    end else if (mode_r == MODE_SMOOTH) begin
      bg_new = q_smooth;
    end else if (!captured_r) begin
      bg_new = {z_r, 8'b0};
    end else begin
      bg_new = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      captured_r <= 1'b0;
    end else if (cmd.update) begin
      if (mode_r != MODE_FIXED) begin
        captured_r <= 1'b0;
      end else if (!captured_r && cap_now) begin
        captured_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      z_r <= in_data.sample;
      p_r <= in_data.channel[IDX_W-1:0];
    end
    if (cmd.update) begin
      bg_r <= bg_new;
    end
  end

  // window widening, one step a cycle
  logic [7:0] lo_r;
  logic [7:0] hi_r;
  logic signed [8:0] span;

  assign span = $signed({1'b0, hi_r}) - $signed({1'b0, lo_r});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_r <= low_r;
      hi_r <= high_r;
    end else if (cmd.widen) begin
      if (lo_r != 8'd0) begin
        lo_r <= lo_r - 8'd1;
      end
      if (hi_r != 8'd255) begin
        hi_r <= hi_r + 8'd1;
      end
    end
  end

  // level and restoring divider
  logic signed [18:0] level;
  logic signed [18:0] num;
  logic [7:0] divisor;
  logic [DVD_W-1:0] dvd_r;
  logic [7:0] rem_r;
  logic [4:0] div_cnt_r;
  logic neg_r;
  logic [8:0] rem_sh;
  logic [8:0] rem_sub;
  logic q_bit;

  always_comb begin
    if (raw) begin
      level = $signed({3'b0, z_r, 8'b0});
    end else begin
      level = VBIAS + $signed({3'b0, z_r, 8'b0}) - $signed({3'b0, bg_r});
    end
    num = level - $signed({3'b0, lo_r, 8'b0});
    divisor = hi_r - lo_r;
    rem_sh = {rem_r, dvd_r[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, divisor};
    q_bit = rem_sh >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dvd_r <= num[DVD_W-1:0];
      neg_r <= num[18];
      rem_r <= 8'd0;
      div_cnt_r <= 5'd0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DVD_W-2:0], q_bit};
      rem_r <= q_bit ? rem_sub[7:0] : rem_sh[7:0];
      div_cnt_r <= div_cnt_r + 5'd1;
    end
  end

  // rainbow map
  function automatic logic [7:0] scale255(input logic [8:0] x);
    logic [16:0] prod;
    prod = 17'(x) * 17'd255;
    return prod[15:8];
  endfunction

  out_item_t colour;
  logic [10:0] t;
  logic [7:0] f;
  logic [8:0] f_up;
  logic [8:0] f_down;

  always_comb begin
    t = 11'(dvd_r[7:0]) * 11'd5;
    f = t[7:0];
    f_up = {1'b0, f};
    f_down = 9'd256 - {1'b0, f};
    colour = '{red: 8'd255, green: 8'd0, blue: 8'd0};
    // negative level or level at or above the top gives red
    if (!neg_r && (dvd_r[DVD_W-1:8] == '0)) begin
      unique case (t[10:8])
        3'd0:    colour = '{red: scale255(f_down), green: 8'd0, blue: 8'd255};
        3'd1:    colour = '{red: 8'd0, green: scale255(f_up), blue: 8'd255};
        3'd2:    colour = '{red: 8'd0, green: 8'd255, blue: scale255(f_down)};
        3'd3:    colour = '{red: scale255(f_up), green: 8'd255, blue: 8'd0};
        default: colour = '{red: 8'd255, green: scale255(f_down), blue: 8'd0};
      endcase
    end
  end

  // output register
  logic out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= colour;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_comb begin
    status.clr_last = (clr_cnt_r == IDX_W'(CHANNELS - 1));
    status.narrow = (span <= 9'sd5);
    status.div_last = (div_cnt_r == DIV_LAST);
    status.out_free = !out_valid_r || !out_stall;
  end

endmodule

`default_nettype wire

// ----- src/spectrum_background_colorizer.sv -----
// one sample in, one pixel out; w = window widening steps per item
// (0 for a window of 6 or more, up to 131 for a reversed one)
// throughput is set by the sequencer, the 17-step restoring divider and the window width
// a pixel passes the read, accumulate, multiply, update, widen, divide and finish states;
// the output register frees the input side so the next sample is taken while a pixel waits
// after reset a clearing pass zeroes all 512 background store entries before any sample
`default_nettype none

module spectrum_background_colorizer
  import sbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  sbc_cmd_t    cmd;
  sbc_status_t status;

  sbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sbc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// self-checking testbench for the spectrum background colorizer
module testbench
  import sbc_pkg::*;
();

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int TOTAL_ITEMS = 900;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_MODE;
  logic [9:0] cfg_data = '0;

  // predicted block state and register copies
  logic [15:0] bg_level [CHANNELS];
  logic bg_locked;
  logic [1:0] reg_mode;
  logic [7:0] reg_low;
  logic [7:0] reg_high;
  logic [9:0] reg_span;

  out_item_t expected_pixels[$];
  int mismatch_count = 0;
  int sent_count = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  int rx_hold_len = 0;

  spectrum_background_colorizer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] shade(input int x);
    return 8'((255 * x) >> 8);
  endfunction

  // updates the background copy and returns the pixel for one sample
  function automatic out_item_t colorize_sample(input in_item_t item);
    int z, p, v, lo, hi, d, num, lvl, t, f, guard;
    logic plain;
    out_item_t px;
    z = item.sample;
    p = item.channel % CHANNELS;
    plain = (reg_mode != MODE_SMOOTH) && (reg_mode != MODE_FIXED);
    if (reg_mode == MODE_SMOOTH)
      bg_level[p] = 16'((10 * int'(bg_level[p]) + z * 256 + 5) / 11);
    if (plain)
      bg_level[p] = '0;
    if (reg_mode == MODE_FIXED && !bg_locked) begin
      bg_level[p] = 16'(z << 8);
      if (p + 1 >= int'(reg_span))
        bg_locked = 1'b1;
    end
    if (reg_mode != MODE_FIXED)
      bg_locked = 1'b0;
    if (plain)
      v = z * 256;
    else
      v = 127 * 256 + z * 256 - int'(bg_level[p]);
    // narrow or reversed window grows one step each side until wider than 5
    lo = reg_low;
    hi = reg_high;
    guard = 0;
    while (guard < 600 && hi - lo <= 5) begin
      if (lo > 0) lo--;
      if (hi < 255) hi++;
      guard++;
    end
    d = (hi - lo < 1) ? 1 : hi - lo;
    num = v - lo * 256;
    px = '{8'd255, 8'd0, 8'd0};
    if (num >= 0) begin
      lvl = num / d;
      if (lvl < 256) begin
        t = 5 * lvl;
        f = t & 255;
        case (t >> 8)
          0: px = '{shade(256 - f), 8'd0, 8'd255};
          1: px = '{8'd0, shade(f), 8'd255};
          2: px = '{8'd0, 8'd255, shade(256 - f)};
          3: px = '{shade(f), 8'd255, 8'd0};
          default: px = '{8'd255, shade(256 - f), 8'd0};
        endcase
      end
    end
    return px;
  endfunction

  task automatic reset_predictor();
    foreach (bg_level[i]) bg_level[i] = '0;
    bg_locked = 1'b0;
    reg_mode = MODE_RAW;
    reg_low = 8'd0;
    reg_high = 8'd255;
    reg_span = 10'd512;
  endtask

  // raises the write enable and leaves it high; configure lowers it once
  task automatic write_reg(input cfg_idx_t idx, input logic [9:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_MODE: reg_mode = value[1:0];
      CFG_LOW: reg_low = value[7:0];
      CFG_HIGH: reg_high = value[7:0];
      CFG_CHANNELS: reg_span = value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [1:0] m, input logic [7:0] lo, input logic [7:0] hi,
                           input logic [9:0] span);
    write_reg(CFG_MODE, 10'(m));
    write_reg(CFG_LOW, 10'(lo));
    write_reg(CFG_HIGH, 10'(hi));
    write_reg(CFG_CHANNELS, span);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input logic [7:0] smp, input logic [8:0] chn);
    in_item_t item;
    item = '{sample: smp, channel: chn};
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    expected_pixels.push_back(colorize_sample(item));
    sent_count++;
  endtask

  // bursts of random length with random gaps
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic test_raw_scale();
    configure(MODE_RAW, 8'd0, 8'd255, 10'd512);
    send_item(8'd0, 9'd0);
    send_item(8'd80, 9'd1);
    send_item(8'd130, 9'd170);
    send_item(8'd180, 9'd341);
    send_item(8'd230, 9'd510);
    send_item(8'd255, 9'd511);
    drain();
  endtask

  task automatic test_window_edges();
    configure(MODE_RAW, 8'd0, 8'd0, 10'd512);
    send_item(8'd3, 9'd5);
    drain();
    configure(MODE_RAW, 8'd255, 8'd255, 10'd512);
    send_item(8'd252, 9'd9);
    send_item(8'd10, 9'd9);
    drain();
    // fully reversed window takes the longest widening
    configure(MODE_RAW, 8'd255, 8'd0, 10'd512);
    send_item(8'd127, 9'd20);
    send_item(8'd0, 9'd21);
    drain();
    configure(MODE_RAW, 8'd200, 8'd100, 10'd512);
    send_item(8'd150, 9'd22);
    drain();
  endtask

  task automatic test_smoothed_background();
    configure(MODE_SMOOTH, 8'd64, 8'd192, 10'd512);
    send_item(8'd255, 9'd300);
    send_item(8'd255, 9'd300);
    send_item(8'd0, 9'd300);
    send_item(8'd127, 9'd511);
    drain();
    // spare mode code acts as raw and wipes the entry
    configure(MODE_SPARE, 8'd64, 8'd192, 10'd512);
    send_item(8'd200, 9'd300);
    drain();
    configure(MODE_SMOOTH, 8'd64, 8'd192, 10'd512);
    send_item(8'd100, 9'd300);
    drain();
  endtask

  task automatic test_fixed_capture();
    configure(MODE_FIXED, 8'd100, 8'd160, 10'd4);
    send_item(8'd10, 9'd0);
    send_item(8'd20, 9'd1);
    send_item(8'd30, 9'd2);
    send_item(8'd40, 9'd3);
    send_item(8'd90, 9'd1);
    drain();
    // a raw sample rearms the capture, then zero channels in use locks at once
    configure(MODE_RAW, 8'd0, 8'd255, 10'd0);
    send_item(8'd77, 9'd7);
    drain();
    configure(MODE_FIXED, 8'd0, 8'd255, 10'd0);
    send_item(8'd50, 9'd7);
    send_item(8'd60, 9'd8);
    drain();
  endtask

  task automatic test_backpressure();
    drain();
    configure(MODE_SMOOTH, 8'd0, 8'd255, 10'd512);
    rx_hold_len = 400;
    repeat (12) send_item(8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
    drain();
  endtask

  task automatic test_random_sweeps();
    logic [1:0] m;
    int lo, hi, span, sweep, base, items, center, smp, chn;
    while (sent_count < TOTAL_ITEMS) begin
      drain();
      case ($urandom_range(0, 7))
        0: m = MODE_RAW;
        1: m = MODE_SPARE;
        2, 3, 4: m = MODE_SMOOTH;
        default: m = MODE_FIXED;
      endcase
      case ($urandom_range(0, 4))
        0: begin
          lo = 0;
          hi = 255;
        end
        1: begin
          lo = $urandom_range(0, 255);
          hi = lo + $urandom_range(0, 6);
          if (hi > 255) hi = 255;
        end
        2: begin
          hi = $urandom_range(0, 255);
          lo = $urandom_range(hi, 255);
        end
        default: begin
          lo = $urandom_range(0, 140);
          hi = $urandom_range(115, 255);
        end
      endcase
      case ($urandom_range(0, 5))
        0: span = $urandom_range(0, 1);
        1: span = 512;
        2: span = 1023;
        3: span = $urandom_range(2, 600);
        default: span = $urandom_range(2, 24);
      endcase
      configure(m, 8'(lo), 8'(hi), 10'(span));
      // sweep ends on the last channel in use so a fixed capture can finish
      sweep = (span < 1) ? 1 : ((span > 32) ? 32 : span);
      base = (span > sweep) ? span - sweep : 0;
      center = $urandom_range(0, 255);
      items = $urandom_range(20, 60);
      for (int k = 0; k < items; k++) begin
        if ($urandom_range(0, 9) < 8) begin
          chn = base + (k % sweep);
          smp = center + $urandom_range(0, 32) - 16;
          if (smp < 0) smp = 0;
          if (smp > 255) smp = 255;
        end else begin
          chn = $urandom_range(0, 511);
          smp = $urandom_range(0, 255);
        end
        send_item(8'(smp), 9'(chn));
        pace();
      end
      if (sent_count > TOTAL_ITEMS / 2 && sent_count < TOTAL_ITEMS / 2 + 60)
        test_backpressure();
    end
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel %h transfer with no sample pending", out_data);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("red", want.red, out_data.red);
        check_field("green", want.green, out_data.green);
        check_field("blue", want.blue, out_data.blue);
      end
    end
  end

  // receiver stall pattern, plus long hold-offs on request
  initial begin
    int seg_left, style, n;
    seg_left = 0;
    style = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        n = rx_hold_len;
        rx_hold_len = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      if (seg_left == 0) begin
        style = $urandom_range(0, 3);
        seg_left = $urandom_range(20, 300);
      end
      seg_left--;
      case (style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    reset_predictor();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // background store clearing pass after reset
    repeat (CHANNELS + 16) @(posedge clk);
    test_raw_scale();
    test_window_edges();
    test_smoothed_background();
    test_fixed_capture();
    test_backpressure();
    test_random_sweeps();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
